// File: hw/rtl/rsnfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsnfe_pkg
// Shared widths, register indexes and limits of the ring slot enumerator.
// ----------------------------------------------------------------------------
package rsnfe_pkg;

	localparam int unsigned CURSOR_W    = 32;
	localparam int unsigned SLOT_W      = 16;
	localparam int unsigned SPAN_W      = SLOT_W + 1;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);

	// two quotient bits retire per divider step
	localparam int unsigned DIV_STEPS   = CURSOR_W / 2;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_MASK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_BIAS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_FIRST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LAST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_RECORDS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORDS_BASE = 3'd6;

	localparam logic [33:0] ADDR_LIMIT = 34'h0_0001_0000;

	localparam logic [CURSOR_W-1:0] CURSOR_MASK_RST = 32'h0000_FFFF;

endpackage
`default_nettype wire

// File: hw/rtl/rsnfe_floor_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsnfe_floor_mod
// Iterative floor modulo of a signed 32-bit value by a 1..65536 divisor.
// ----------------------------------------------------------------------------
module rsnfe_floor_mod (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              go,
	input  wire logic [rsnfe_pkg::CURSOR_W-1:0]    dividend,
	input  wire logic [rsnfe_pkg::SPAN_W-1:0]      divisor,
	output logic                                   done,
	output logic [rsnfe_pkg::SLOT_W-1:0]           modulo
);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_RUN  = 2'd1;
	localparam logic [1:0] D_FIX  = 2'd2;

	logic [1:0]                          phase_q;
	logic [rsnfe_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                                done_q;
	logic                                neg_q;
	logic [rsnfe_pkg::CURSOR_W-1:0]      mag_q;
	logic [rsnfe_pkg::SLOT_W-1:0]        rem_q;
	logic [rsnfe_pkg::SLOT_W-1:0]        mod_q;

	logic [rsnfe_pkg::SPAN_W-1:0]        t1, r1, t2, r2;

	// two restoring steps per cycle; each partial remainder stays below divisor
	always_comb begin
		t1 = {rem_q, mag_q[rsnfe_pkg::CURSOR_W-1]};
		r1 = (t1 >= divisor) ? (t1 - divisor) : t1;
		t2 = {r1[rsnfe_pkg::SLOT_W-1:0], mag_q[rsnfe_pkg::CURSOR_W-2]};
		r2 = (t2 >= divisor) ? (t2 - divisor) : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				D_IDLE: begin
					if (go) begin
						phase_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (cnt_q == rsnfe_pkg::DIV_CNT_W'(rsnfe_pkg::DIV_STEPS - 1)) begin
						phase_q <= D_FIX;
					end
				end
				D_FIX: begin
					done_q  <= 1'b1;
					phase_q <= D_IDLE;
				end
				default: begin
					phase_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			D_IDLE: begin
				neg_q <= dividend[rsnfe_pkg::CURSOR_W-1];
				mag_q <= dividend[rsnfe_pkg::CURSOR_W-1] ? (~dividend + 1'b1) : dividend;
				rem_q <= '0;
				cnt_q <= '0;
			end
			D_RUN: begin
				rem_q <= r2[rsnfe_pkg::SLOT_W-1:0];
				mag_q <= {mag_q[rsnfe_pkg::CURSOR_W-3:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
			end
			D_FIX: begin
				// negative dividend with a nonzero remainder folds back up
				if (neg_q && (rem_q != '0)) begin
					mod_q <= rsnfe_pkg::SLOT_W'(divisor - {1'b0, rem_q});
				end else begin
					mod_q <= rem_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign done   = done_q;
	assign modulo = mod_q;

endmodule
`default_nettype wire

// File: hw/rtl/ring_slot_newest_first_enumerator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_slot_newest_first_enumerator
// Locates the latest ring slot from a write cursor and lists slots newest
// first, each with its record address and a 64 KiB fit flag.
// ----------------------------------------------------------------------------
//
// channel   | handshake               | payload
// ----------+-------------------------+--------------------------------------
// command   | start / busy            | write_cursor, want_count
// result    | result_valid (strobe)   | slot_number, record_addr, addr_ok,
//           |                         | status, last_of_run
// config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Sequence: an item with a good layout passes a prep state, the floor-mod unit
// (load, 16 two-bit steps, sign fix) and a handoff state, then emits one result
// per cycle through the multiply/add pipeline (product, then base add and fit
// check). A bad layout emits a single error item straight from the prep state.
// The floor-mod unit's 16 dependent steps and the emit rate set the run time.
// Reset: arst_n clears control state and loads register reset values.
// Stalls: the receiver cannot stall; busy stays high until the last item of
// the run has been on the result ports. cfg_ready is always high.
//
module ring_slot_newest_first_enumerator (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [rsnfe_pkg::CURSOR_W-1:0]        write_cursor,
	input  wire logic [rsnfe_pkg::SLOT_W-1:0]          want_count,
	output logic                                       result_valid,
	output logic [rsnfe_pkg::SLOT_W-1:0]               slot_number,
	output logic [rsnfe_pkg::SLOT_W-1:0]               record_addr,
	output logic                                       addr_ok,
	output logic                                       status,
	output logic                                       last_of_run,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [rsnfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rsnfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	// configuration registers
	logic [rsnfe_pkg::CURSOR_W-1:0]  cursor_mask_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    cursor_bias_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    slot_first_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    slot_last_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    ring_records_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    record_bytes_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    records_base_q;

	// sequencer
	logic [1:0]                      state_q;
	logic [rsnfe_pkg::CURSOR_W-1:0]  cursor_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    want_q;
	logic [rsnfe_pkg::CURSOR_W-1:0]  diff_q;
	logic [rsnfe_pkg::SPAN_W-1:0]    span_q;
	logic [rsnfe_pkg::COUNT_W-1:0]   left_q;
	logic [rsnfe_pkg::SLOT_W-1:0]    slot_q;
	logic                            div_go_q;

	// emit stage 1: product
	logic                            valid_s1;
	logic                            err_s1;
	logic                            last_s1;
	logic [rsnfe_pkg::SLOT_W-1:0]    slot_s1;
	logic [rsnfe_pkg::CURSOR_W-1:0]  prod_s1;

	// emit stage 2: result ports
	logic                            valid_s2;
	logic [rsnfe_pkg::SLOT_W-1:0]    slot_s2;
	logic [rsnfe_pkg::SLOT_W-1:0]    addr_s2;
	logic                            ok_s2;
	logic                            err_s2;
	logic                            last_s2;

	logic                            div_done;
	logic [rsnfe_pkg::SLOT_W-1:0]    div_mod;

	logic                            bad_layout;
	logic [rsnfe_pkg::CURSOR_W-1:0]  biased;
	logic [rsnfe_pkg::SPAN_W-1:0]    span;
	logic [rsnfe_pkg::SPAN_W-1:0]    avail;
	logic [rsnfe_pkg::SPAN_W-1:0]    pick;
	logic [rsnfe_pkg::COUNT_W-1:0]   count;
	logic [32:0]                     addr_sum;
	logic [33:0]                     addr_end;
	logic                            addr_fits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_mask_q  <= rsnfe_pkg::CURSOR_MASK_RST;
			cursor_bias_q  <= '0;
			slot_first_q   <= '0;
			slot_last_q    <= '0;
			ring_records_q <= '0;
			record_bytes_q <= '0;
			records_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rsnfe_pkg::CFG_CURSOR_MASK:  cursor_mask_q  <= cfg_data;
				rsnfe_pkg::CFG_CURSOR_BIAS:  cursor_bias_q  <= cfg_data[rsnfe_pkg::SLOT_W-1:0];
				rsnfe_pkg::CFG_SLOT_FIRST:   slot_first_q   <= cfg_data[rsnfe_pkg::SLOT_W-1:0];
				rsnfe_pkg::CFG_SLOT_LAST:    slot_last_q    <= cfg_data[rsnfe_pkg::SLOT_W-1:0];
				rsnfe_pkg::CFG_RING_RECORDS: ring_records_q <= cfg_data[rsnfe_pkg::SLOT_W-1:0];
				rsnfe_pkg::CFG_RECORD_BYTES: record_bytes_q <= cfg_data[rsnfe_pkg::SLOT_W-1:0];
				rsnfe_pkg::CFG_RECORDS_BASE: records_base_q <= cfg_data[rsnfe_pkg::SLOT_W-1:0];
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	// prep arithmetic: bias the masked cursor, size the run
	always_comb begin
		bad_layout = (ring_records_q == '0) || (record_bytes_q == '0) ||
		             (slot_last_q < slot_first_q);
		biased = (cursor_q & cursor_mask_q) +
		         {{(rsnfe_pkg::CURSOR_W - rsnfe_pkg::SLOT_W){cursor_bias_q[rsnfe_pkg::SLOT_W-1]}},
		          cursor_bias_q};
		span  = {1'b0, slot_last_q} - {1'b0, slot_first_q} + 1'b1;
		avail = ({1'b0, ring_records_q} < span) ? {1'b0, ring_records_q} : span;
		pick  = ((want_q == '0) || ({1'b0, want_q} > avail)) ? avail : {1'b0, want_q};
		count = (pick > rsnfe_pkg::SPAN_W'(rsnfe_pkg::MAX_RESULTS)) ?
		        rsnfe_pkg::COUNT_W'(rsnfe_pkg::MAX_RESULTS) : pick[rsnfe_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			div_go_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			valid_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (bad_layout) begin
						// one error item ends the run
						valid_s1 <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					valid_s1 <= 1'b1;
					if (left_q == rsnfe_pkg::COUNT_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cursor_q <= write_cursor;
				want_q   <= want_count;
			end
			S_PREP: begin
				diff_q  <= biased - {{(rsnfe_pkg::CURSOR_W - rsnfe_pkg::SLOT_W){1'b0}}, slot_first_q};
				span_q  <= span;
				left_q  <= count;
				err_s1  <= 1'b1;
				last_s1 <= 1'b1;
				slot_s1 <= '0;
				prod_s1 <= '0;
			end
			S_DIV: begin
				// latest slot sits inside the window, so 16 bits hold it
				slot_q <= slot_first_q + div_mod;
			end
			S_EMIT: begin
				err_s1  <= 1'b0;
				last_s1 <= (left_q == rsnfe_pkg::COUNT_W'(1));
				slot_s1 <= slot_q;
				prod_s1 <= {{(rsnfe_pkg::CURSOR_W - rsnfe_pkg::SLOT_W){1'b0}}, slot_q} *
				           {{(rsnfe_pkg::CURSOR_W - rsnfe_pkg::SLOT_W){1'b0}}, record_bytes_q};
				left_q  <= left_q - 1'b1;
				// step back one slot, wrap from the window floor to its top
				slot_q  <= (slot_q == slot_first_q) ? slot_last_q : (slot_q - 1'b1);
			end
			default: begin
				left_q <= '0;
			end
		endcase
	end

	rsnfe_floor_mod u_floor_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (diff_q),
		.divisor  (span_q),
		.done     (div_done),
		.modulo   (div_mod)
	);

	// stage 2: add the base, check the record end against 64 KiB
	always_comb begin
		addr_sum  = {1'b0, prod_s1} + 33'(records_base_q);
		addr_end  = {1'b0, addr_sum} + 34'(record_bytes_q);
		addr_fits = (addr_end <= rsnfe_pkg::ADDR_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			slot_s2 <= slot_s1;
			err_s2  <= err_s1;
			last_s2 <= last_s1;
			ok_s2   <= !err_s1 && addr_fits;
			addr_s2 <= (!err_s1 && addr_fits) ? addr_sum[rsnfe_pkg::SLOT_W-1:0] : '0;
		end
	end

	// hold busy until the last item has left the result ports
	assign busy         = (state_q != S_IDLE) || valid_s1 || valid_s2;
	assign result_valid = valid_s2;
	assign slot_number  = slot_s2;
	assign record_addr  = addr_s2;
	assign addr_ok      = ok_s2;
	assign status       = err_s2;
	assign last_of_run  = last_s2;

`ifndef NO_ASSERTIONS
	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result item shown while idle");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status) |-> (last_of_run && !addr_ok && (slot_number == '0)))
		else $error("error item malformed");

	a_addr_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !addr_ok) |-> (record_addr == '0))
		else $error("record address leaked for a record past 64 KiB");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |=> !result_valid)
		else $error("result item after the last of the run");
`endif

endmodule
`default_nettype wire

// File: tb/ring_slot_newest_first_enumerator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_slot_newest_first_enumerator_tb
// Drives cursor reads into the ring slot enumerator under a series of window
// layouts, predicts each newest-first slot listing and compares every result.
// ----------------------------------------------------------------------------
module ring_slot_newest_first_enumerator_tb;

	// register index with no register behind it; writes must be dropped
	localparam logic [rsnfe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam logic ST_OK         = 1'b0;
	localparam logic ST_BAD_LAYOUT = 1'b1;

	localparam logic CHECK_FIXED = 1'b1;
	localparam logic CHECK_CALC  = 1'b0;

	localparam int unsigned CYCLE_LIMIT   = 300000;
	localparam int unsigned RANDOM_ITEMS  = 250;
	localparam int unsigned PHASE_ITEMS   = 25;
	localparam int unsigned QUIET_FROM    = 200;
	localparam int unsigned DRAIN_CYCLES  = 100;

	typedef struct packed {
		logic [rsnfe_pkg::SLOT_W-1:0] slot;
		logic [rsnfe_pkg::SLOT_W-1:0] addr;
		logic                         ok;
		logic                         stat;
		logic                         last;
	} slot_rec_t;

	typedef struct packed {
		logic [rsnfe_pkg::CURSOR_W-1:0] mask;
		logic [rsnfe_pkg::SLOT_W-1:0]   bias;
		logic [rsnfe_pkg::SLOT_W-1:0]   first;
		logic [rsnfe_pkg::SLOT_W-1:0]   last;
		logic [rsnfe_pkg::SLOT_W-1:0]   recs;
		logic [rsnfe_pkg::SLOT_W-1:0]   bytes;
		logic [rsnfe_pkg::SLOT_W-1:0]   base;
	} layout_t;

	typedef struct packed {
		layout_t                        lay;
		logic [rsnfe_pkg::CURSOR_W-1:0] cursor;
		logic [rsnfe_pkg::SLOT_W-1:0]   limit;
		logic                           fixed;
		slot_rec_t                      res;
	} probe_t;

	localparam slot_rec_t BAD_LAYOUT_RES = '{16'h0, 16'h0, 1'b0, ST_BAD_LAYOUT, 1'b1};

	// window layouts of the directed part
	localparam layout_t LAY_RESET    = '{rsnfe_pkg::CURSOR_MASK_RST, 16'h0, 16'h0, 16'h0, 16'h0,
		16'h0, 16'h0};
	localparam layout_t LAY_NO_RECS  = '{32'h0000_FFFF, 16'h0, 16'd0, 16'd9, 16'd0, 16'd4,
		16'h0};
	localparam layout_t LAY_NO_BYTES = '{32'h0000_FFFF, 16'h0, 16'd0, 16'd9, 16'd10, 16'd0,
		16'h0};
	localparam layout_t LAY_INVERTED = '{32'h0000_FFFF, 16'h0, 16'd5, 16'd4, 16'd10, 16'd4,
		16'h0};
	localparam layout_t LAY_ONE_SLOT = '{32'h0000_FFFF, 16'h0, 16'd0, 16'd0, 16'd1, 16'd1,
		16'h0};
	localparam layout_t LAY_FULL     = '{32'hFFFF_FFFF, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF,
		16'd1, 16'h0};
	localparam layout_t LAY_TALL_REC = '{32'h0000_FFFF, 16'h0, 16'd0, 16'd15, 16'd16,
		16'h1000, 16'h0001};
	localparam layout_t LAY_NEG_BIAS = '{32'h0, 16'h8000, 16'd100, 16'd199, 16'd50, 16'hFFFF,
		16'hFFFF};
	localparam layout_t LAY_TOP_SLOT = '{32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'd1, 16'h0};
	localparam layout_t LAY_WRAP     = '{32'hFFFF_FFFF, 16'h7FFF, 16'd3, 16'd12, 16'd200, 16'd2,
		16'h0100};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic [rsnfe_pkg::CURSOR_W-1:0]      write_cursor = '0;
	logic [rsnfe_pkg::SLOT_W-1:0]        want_count = '0;
	logic                                result_valid;
	logic [rsnfe_pkg::SLOT_W-1:0]        slot_number;
	logic [rsnfe_pkg::SLOT_W-1:0]        record_addr;
	logic                                addr_ok;
	logic                                status;
	logic                                last_of_run;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [rsnfe_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [rsnfe_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

	// register image as the block should hold it
	logic [rsnfe_pkg::CURSOR_W-1:0]      cur_mask = rsnfe_pkg::CURSOR_MASK_RST;
	logic [rsnfe_pkg::SLOT_W-1:0]        cur_bias = '0;
	logic [rsnfe_pkg::SLOT_W-1:0]        slot_lo = '0;
	logic [rsnfe_pkg::SLOT_W-1:0]        slot_hi = '0;
	logic [rsnfe_pkg::SLOT_W-1:0]        ring_recs = '0;
	logic [rsnfe_pkg::SLOT_W-1:0]        rec_bytes = '0;
	logic [rsnfe_pkg::SLOT_W-1:0]        rec_base = '0;
	layout_t                             loaded = LAY_RESET;

	slot_rec_t              slots_due [$];
	slot_rec_t              due_head;
	probe_t                 probes [20];
	logic                   start_held = 1'b0;
	int unsigned            fail_count = 0;
	int unsigned            cycle_count = 0;

	ring_slot_newest_first_enumerator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.write_cursor (write_cursor),
		.want_count   (want_count),
		.result_valid (result_valid),
		.slot_number  (slot_number),
		.record_addr  (record_addr),
		.addr_ok      (addr_ok),
		.status       (status),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Work out the listing one cursor read should produce and queue it.
	function automatic void enumerate_slots(input logic [rsnfe_pkg::CURSOR_W-1:0] cursor,
			input logic [rsnfe_pkg::SLOT_W-1:0] limit);
		logic [rsnfe_pkg::CURSOR_W-1:0] bias_x;
		logic [rsnfe_pkg::CURSOR_W-1:0] biased;
		logic [rsnfe_pkg::CURSOR_W-1:0] offset;
		longint span;
		longint rem;
		longint avail;
		longint count;
		longint rel;
		longint slot;
		longint addr;
		logic fits;
		slot_rec_t res;
		if (ring_recs == 0 || rec_bytes == 0 || slot_hi < slot_lo) begin
			slots_due = {slots_due, BAD_LAYOUT_RES};
			return;
		end
		bias_x = {{16{cur_bias[15]}}, cur_bias};
		biased = (cursor & cur_mask) + bias_x;
		offset = biased - {16'h0, slot_lo};
		span = longint'(slot_hi) - longint'(slot_lo) + 1;
		// floor-wrap: C-style remainder, then pull negatives into range
		rem = longint'($signed(offset)) % span;
		if (rem < 0)
			rem += span;
		avail = (longint'(ring_recs) < span) ? longint'(ring_recs) : span;
		count = (limit == 0 || longint'(limit) > avail) ? avail : longint'(limit);
		if (count > longint'(rsnfe_pkg::MAX_RESULTS))
			count = longint'(rsnfe_pkg::MAX_RESULTS);
		for (longint k = 0; k < count; k++) begin
			rel = (rem + span - (k % span)) % span;
			slot = longint'(slot_lo) + rel;
			addr = longint'(rec_base) + slot * longint'(rec_bytes);
			fits = (addr + longint'(rec_bytes) <= longint'(rsnfe_pkg::ADDR_LIMIT));
			res.slot = 16'(slot);
			res.addr = fits ? 16'(addr) : 16'h0;
			res.ok = fits;
			res.stat = ST_OK;
			res.last = (k + 1 == count);
			slots_due = {slots_due, res};
		end
	endfunction

	function automatic layout_t random_layout();
		layout_t lay;
		longint span;
		case ($urandom_range(0, 4))
			0: lay.mask = 32'h0000_FFFF;
			1: lay.mask = 32'hFFFF_FFFF;
			2: lay.mask = 32'h0000_00FF;
			3: lay.mask = $urandom & 32'h000F_FFFF;
			default: lay.mask = $urandom;
		endcase
		case ($urandom_range(0, 3))
			0: lay.bias = 16'h8000;
			1: lay.bias = 16'h7FFF;
			2: lay.bias = 16'($urandom_range(0, 16)) - 16'd8;
			default: lay.bias = 16'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: lay.first = 16'h0;
			1: lay.first = 16'($urandom_range(65000, 65535));
			default: lay.first = 16'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0: span = $urandom_range(1, 8);
			1: span = $urandom_range(1, 300);
			default: span = $urandom_range(1, 65536);
		endcase
		if (longint'(lay.first) + span - 1 > 65535)
			lay.last = 16'hFFFF;
		else
			lay.last = 16'(longint'(lay.first) + span - 1);
		lay.recs = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 100))
			: 16'($urandom_range(1, 65535));
		case ($urandom_range(0, 2))
			0: lay.bytes = 16'($urandom_range(1, 16));
			1: lay.bytes = 16'($urandom_range(1, 4096));
			default: lay.bytes = 16'($urandom_range(1, 65535));
		endcase
		lay.base = 16'($urandom);
		// now and then break the layout one way or another
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: lay.recs = 16'h0;
				1: lay.bytes = 16'h0;
				default: begin
					if (lay.first == 0)
						lay.first = 16'($urandom_range(1, 65535));
					lay.last = 16'($urandom_range(0, lay.first - 1));
				end
			endcase
		end
		return lay;
	endfunction

	function automatic logic [rsnfe_pkg::CURSOR_W-1:0] random_cursor();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 65535));
			1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
			2: return 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [rsnfe_pkg::SLOT_W-1:0] random_limit();
		case ($urandom_range(0, 3))
			0: return 16'h0;
			1: return 16'($urandom_range(1, 8));
			2: return 16'($urandom_range(9, 80));
			default: return 16'($urandom);
		endcase
	endfunction

	// Lower start once; the flag keeps a second drop out of the same step.
	task automatic drop_start();
		if (start_held) begin
			start <= 1'b0;
			start_held = 1'b0;
		end
	endtask

	// Offer one item and hold it until the block takes it; then predict.
	task automatic send_item(input logic [rsnfe_pkg::CURSOR_W-1:0] cursor,
			input logic [rsnfe_pkg::SLOT_W-1:0] limit,
			input logic fixed, input slot_rec_t fixed_res);
		if (!start_held) begin
			start <= 1'b1;
			start_held = 1'b1;
		end
		write_cursor <= cursor;
		want_count <= limit;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (fixed)
			slots_due = {slots_due, fixed_res};
		else
			enumerate_slots(cursor, limit);
	endtask

	task automatic idle_burst();
		if ($urandom_range(0, 2) == 0) begin
			drop_start();
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	// Hold off until every queued result is in and the block is idle.
	task automatic wait_drained();
		drop_start();
		while (slots_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	// cfg_valid stays up across a burst of writes; the caller lowers it.
	task automatic write_reg(input logic [rsnfe_pkg::CFG_IDX_W-1:0] idx,
			input logic [rsnfe_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rsnfe_pkg::CFG_CURSOR_MASK:  cur_mask = data;
			rsnfe_pkg::CFG_CURSOR_BIAS:  cur_bias = data[15:0];
			rsnfe_pkg::CFG_SLOT_FIRST:   slot_lo = data[15:0];
			rsnfe_pkg::CFG_SLOT_LAST:    slot_hi = data[15:0];
			rsnfe_pkg::CFG_RING_RECORDS: ring_recs = data[15:0];
			rsnfe_pkg::CFG_RECORD_BYTES: rec_bytes = data[15:0];
			rsnfe_pkg::CFG_RECORDS_BASE: rec_base = data[15:0];
			default: ;
		endcase
	endtask

	// Upper halves of the 16-bit registers carry junk that must be dropped.
	task automatic load_layout(input layout_t lay);
		write_reg(rsnfe_pkg::CFG_CURSOR_MASK, lay.mask);
		write_reg(rsnfe_pkg::CFG_CURSOR_BIAS, {16'($urandom), lay.bias});
		write_reg(rsnfe_pkg::CFG_SLOT_FIRST, {16'($urandom), lay.first});
		write_reg(rsnfe_pkg::CFG_SLOT_LAST, {16'($urandom), lay.last});
		write_reg(rsnfe_pkg::CFG_RING_RECORDS, {16'($urandom), lay.recs});
		write_reg(rsnfe_pkg::CFG_RECORD_BYTES, {16'($urandom), lay.bytes});
		write_reg(rsnfe_pkg::CFG_RECORDS_BASE, {16'($urandom), lay.base});
		write_reg(CFG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		loaded = lay;
	endtask

	// Compare every strobed result against the oldest queued expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (slots_due.size() == 0) begin
				$error("unexpected result: slot_number %0h record_addr %0h status %0b",
					slot_number, record_addr, status);
				fail_count++;
			end else begin
				due_head = slots_due.pop_front();
				if (slot_number !== due_head.slot) begin
					$error("slot_number: expected %0h, got %0h", due_head.slot, slot_number);
					fail_count++;
				end
				if (record_addr !== due_head.addr) begin
					$error("record_addr: expected %0h, got %0h", due_head.addr, record_addr);
					fail_count++;
				end
				if (addr_ok !== due_head.ok) begin
					$error("addr_ok: expected %0b, got %0b", due_head.ok, addr_ok);
					fail_count++;
				end
				if (status !== due_head.stat) begin
					$error("status: expected %0b, got %0b", due_head.stat, status);
					fail_count++;
				end
				if (last_of_run !== due_head.last) begin
					$error("last_of_run: expected %0b, got %0b", due_head.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: no correct run comes anywhere near this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned n;
		// Directed rows: bad layouts from every cause, single-slot windows, the
		// full 64K window with the count cap, cursor wrap at both signed
		// extremes, records running past 64 KiB, and the bias extremes.
		// Rows marked fixed carry their result; the rest go to the predictor.
		probes = '{
			'{LAY_RESET,    32'h0,         16'h0,    CHECK_FIXED, BAD_LAYOUT_RES},
			'{LAY_NO_RECS,  32'h5,         16'h0,    CHECK_FIXED, BAD_LAYOUT_RES},
			'{LAY_NO_BYTES, 32'h5,         16'h3,    CHECK_FIXED, BAD_LAYOUT_RES},
			'{LAY_INVERTED, 32'hFFFF_FFFF, 16'hFFFF, CHECK_FIXED, BAD_LAYOUT_RES},
			'{LAY_ONE_SLOT, 32'h0,         16'h0,    CHECK_FIXED,
				'{16'h0, 16'h0, 1'b1, ST_OK, 1'b1}},
			'{LAY_ONE_SLOT, 32'hFFFF_FFFF, 16'hFFFF, CHECK_FIXED,
				'{16'h0, 16'h0, 1'b1, ST_OK, 1'b1}},
			'{LAY_FULL,     32'hFFFF_FFFF, 16'h0,    CHECK_CALC,  '0},
			'{LAY_FULL,     32'h8000_0000, 16'h1,    CHECK_FIXED,
				'{16'h0, 16'h0, 1'b1, ST_OK, 1'b1}},
			'{LAY_FULL,     32'h7FFF_FFFF, 16'h1,    CHECK_FIXED,
				'{16'hFFFF, 16'hFFFF, 1'b1, ST_OK, 1'b1}},
			'{LAY_FULL,     32'h1234_5678, 16'd70,   CHECK_CALC,  '0},
			'{LAY_TALL_REC, 32'd15,        16'h1,    CHECK_FIXED,
				'{16'd15, 16'h0, 1'b0, ST_OK, 1'b1}},
			'{LAY_TALL_REC, 32'd14,        16'h1,    CHECK_FIXED,
				'{16'd14, 16'hE001, 1'b1, ST_OK, 1'b1}},
			'{LAY_TALL_REC, 32'd15,        16'h0,    CHECK_CALC,  '0},
			'{LAY_TALL_REC, 32'd3,         16'h3,    CHECK_CALC,  '0},
			'{LAY_NEG_BIAS, 32'h0,         16'h1,    CHECK_FIXED,
				'{16'd132, 16'h0, 1'b0, ST_OK, 1'b1}},
			'{LAY_NEG_BIAS, 32'h0,         16'h0,    CHECK_CALC,  '0},
			'{LAY_TOP_SLOT, 32'hFFFF_FFFF, 16'h0,    CHECK_FIXED,
				'{16'hFFFF, 16'hFFFF, 1'b1, ST_OK, 1'b1}},
			'{LAY_WRAP,     32'h7FFF_FFFF, 16'h0,    CHECK_CALC,  '0},
			'{LAY_WRAP,     32'hFFFF_FFFF, 16'hFFFF, CHECK_CALC,  '0},
			'{LAY_WRAP,     32'h1234_5678, 16'h4,    CHECK_CALC,  '0}
		};

		// hold reset, then release it for good
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// The first row runs on the reset register values, so no load there.
		foreach (probes[i]) begin
			if (probes[i].lay != loaded) begin
				wait_drained();
				load_layout(probes[i].lay);
			end
			send_item(probes[i].cursor, probes[i].limit, probes[i].fixed, probes[i].res);
			idle_burst();
		end

		// Random phases: each one drains the block, loads a fresh layout and
		// fires a run of cursor reads; items from QUIET_FROM on go without gaps.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_ITEMS == 0) begin
				wait_drained();
				load_layout(random_layout());
			end
			send_item(random_cursor(), random_limit(), CHECK_CALC, '0);
			if (n < QUIET_FROM)
				idle_burst();
		end

		// drain, then watch a while longer for stray strobes
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rsnfe_pkg.sv
hw/rtl/rsnfe_floor_mod.sv
hw/rtl/ring_slot_newest_first_enumerator.sv
tb/ring_slot_newest_first_enumerator_tb.sv
